// File: rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, tables and round functions for the aes-128 engine
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned ROUNDS    = 10;
    localparam int unsigned KEY_WORDS = 4 * (ROUNDS + 1);

    typedef logic [127:0] block_t;
    typedef logic [31:0]  word_t;
    typedef logic [7:0]   byte_t;

    typedef enum logic {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } mode_t;

    typedef enum logic {
        REG_KEY_UPPER = 1'b0,
        REG_KEY_LOWER = 1'b1
    } reg_idx_t;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam byte_t RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // state byte n sits at bits 127-8n .. 120-8n
    function automatic byte_t get_byte(input block_t s, input int unsigned n);
        return s[127 - 8*n -: 8];
    endfunction

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic word_t sub_word(input word_t w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127 - 8*(4*c + r) -: 8] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
            end
        end
        return o;
    endfunction

    function automatic block_t inv_shift_sub(input block_t s);
        block_t o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127 - 8*(4*c + r) -: 8] = INV_SBOX[get_byte(s, 4*((c + 4 - r) % 4) + r)];
            end
        end
        return o;
    endfunction

    function automatic block_t mix_cols(input block_t s);
        block_t o;
        byte_t  a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            o[127 - 32*c -: 32] = {
                xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)
            };
        end
        return o;
    endfunction

    function automatic block_t inv_mix_cols(input block_t s);
        block_t o;
        byte_t  a0, a1, a2, a3, u, v;
        block_t t;
        // preconditioning: inverse = forward mix of a 04/05 premultiplied column
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            u  = xtime(xtime(a0 ^ a2));
            v  = xtime(xtime(a1 ^ a3));
            t[127 - 32*c -: 32] = {a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v};
        end
        o = mix_cols(t);
        return o;
    endfunction

endpackage

// File: rtl/aes128_block_cipher.sv
// ----------------------------------------------------------------------------
// aes128_block_cipher
// fully unrolled aes-128 encrypt/decrypt pipeline with a registered key schedule
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   129    tuser mode, tdata block
//  m_axis    out  128    tdata result block
//  cfg       in   64     key halves, index 0 upper, 1 lower
//
//  one transaction accepted per cycle while the output is not stalled and no key sweep runs;
//  results pass the whitening register, then ten round registers
//  a key write starts a schedule sweep that holds off input; blocks then use the new key
//  reset clears the valid bits and the key, and sweeps in the schedule of the all-zero key
//  m_tready low with a valid result holds every stage in place; nothing is dropped or repeated
module aes128_block_cipher (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  aes_pkg::block_t s_tdata,   // block_upper, block_lower (lowest bits first)
    input  logic            s_tuser,   // mode
    output logic            m_tvalid,
    input  logic            m_tready,
    output aes_pkg::block_t m_tdata,   // out_upper, out_lower (lowest bits first)
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [63:0]     cfg_wdata
);

    localparam int unsigned NST = aes_pkg::ROUNDS + 1;

    aes_pkg::word_t      rk_reg [aes_pkg::KEY_WORDS];
    aes_pkg::block_t     ks_key_reg;
    aes_pkg::block_t     ks_key_next;
    aes_pkg::word_t      ks_g;
    logic [3:0]          ks_cnt_reg;
    logic                ks_busy_reg;

    logic                vld_reg  [NST];
    logic                mode_reg [NST];
    aes_pkg::block_t     st_reg   [NST];
    logic                adv;
    aes_pkg::block_t     blk_in;

    // key schedule: one round key per cycle after a write, restarted by any further write
    assign ks_g = aes_pkg::sub_word({ks_key_reg[23:0], ks_key_reg[31:24]}) ^
        {aes_pkg::RCON[ks_cnt_reg], 24'h0};

    always_comb begin
        ks_key_next[127:96] = ks_key_reg[127:96] ^ ks_g;
        ks_key_next[95:64]  = ks_key_reg[95:64] ^ ks_key_next[127:96];
        ks_key_next[63:32]  = ks_key_reg[63:32] ^ ks_key_next[95:64];
        ks_key_next[31:0]   = ks_key_reg[31:0] ^ ks_key_next[63:32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ks_key_reg  <= '0;
            ks_cnt_reg  <= '0;
            ks_busy_reg <= 1'b1;
            for (int i = 0; i < 4; i++) rk_reg[i] <= '0;
        end else if (cfg_we) begin
            if (cfg_index == aes_pkg::REG_KEY_UPPER) begin
                rk_reg[0]  <= cfg_wdata[63:32];
                rk_reg[1]  <= cfg_wdata[31:0];
                ks_key_reg <= {cfg_wdata, rk_reg[2], rk_reg[3]};
            end else begin
                rk_reg[2]  <= cfg_wdata[63:32];
                rk_reg[3]  <= cfg_wdata[31:0];
                ks_key_reg <= {rk_reg[0], rk_reg[1], cfg_wdata};
            end
            ks_cnt_reg  <= '0;
            ks_busy_reg <= 1'b1;
        end else if (ks_busy_reg) begin
            ks_key_reg <= ks_key_next;
            for (int r = 0; r < aes_pkg::ROUNDS; r++) begin
                if (ks_cnt_reg == 4'(r)) begin
                    rk_reg[4*r+4] <= ks_key_next[127:96];
                    rk_reg[4*r+5] <= ks_key_next[95:64];
                    rk_reg[4*r+6] <= ks_key_next[63:32];
                    rk_reg[4*r+7] <= ks_key_next[31:0];
                end
            end
            if (ks_cnt_reg == 4'(aes_pkg::ROUNDS - 1)) begin
                ks_busy_reg <= 1'b0;
            end else begin
                ks_cnt_reg <= ks_cnt_reg + 4'd1;
            end
        end
    end

    function automatic aes_pkg::block_t rkey(input int unsigned r);
        return {rk_reg[4*r], rk_reg[4*r+1], rk_reg[4*r+2], rk_reg[4*r+3]};
    endfunction

    // pipeline: stage 0 whitening, stages 1..10 rounds
    assign blk_in   = {s_tdata[63:0], s_tdata[127:64]};
    assign adv      = m_tready || !vld_reg[NST-1];
    assign s_tready = adv && !ks_busy_reg;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {st_reg[NST-1][63:0], st_reg[NST-1][127:64]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NST; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_tvalid && s_tready;
            for (int i = 1; i < NST; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode_reg[0] <= s_tuser;
            st_reg[0]   <= blk_in ^
                (s_tuser == aes_pkg::MODE_DEC ? rkey(aes_pkg::ROUNDS) : rkey(0));
            for (int i = 1; i < NST; i++) begin
                mode_reg[i] <= mode_reg[i-1];
                if (mode_reg[i-1] == aes_pkg::MODE_ENC) begin
                    if (i == NST - 1) begin
                        st_reg[i] <= aes_pkg::sub_shift(st_reg[i-1]) ^ rkey(i);
                    end else begin
                        st_reg[i] <= aes_pkg::mix_cols(aes_pkg::sub_shift(st_reg[i-1])) ^
                            rkey(i);
                    end
                end else begin
                    if (i == NST - 1) begin
                        st_reg[i] <= aes_pkg::inv_shift_sub(st_reg[i-1]) ^
                            rkey(aes_pkg::ROUNDS - i);
                    end else begin
                        st_reg[i] <= aes_pkg::inv_mix_cols(
                            aes_pkg::inv_shift_sub(st_reg[i-1]) ^
                            rkey(aes_pkg::ROUNDS - i));
                    end
                end
            end
        end
    end

endmodule

// File: rtl/aes_checker.sv
// ----------------------------------------------------------------------------
// aes_checker
// port-level checks for the aes-128 engine
// ----------------------------------------------------------------------------
module aes_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         cfg_we
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // no input while key schedule reloads
    a_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("input taken during key expansion");

    // no result right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled full output blocks the input
    a_backp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we)
);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the aes-128 encrypt/decrypt pipeline: an in-bench
// cipher computes every result from the current key, keys are changed between
// idle phases, and both stream sides are throttled at random
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        aes_pkg::mode_t mode;
        logic [63:0]    hi;
        logic [63:0]    lo;
    } blk_item_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } blk_out_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [127:0]      s_tdata = '0;
    aes_pkg::mode_t    s_tuser = aes_pkg::MODE_ENC;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [127:0]      m_tdata;
    logic              cfg_we = 1'b0;
    aes_pkg::reg_idx_t cfg_index = aes_pkg::REG_KEY_UPPER;
    logic [63:0]       cfg_wdata = '0;

    blk_item_t pend_q[$];
    blk_out_t  cipher_q[$];
    aes_pkg::byte_t sb[256];
    aes_pkg::byte_t isb[256];
    aes_pkg::word_t sched[44];
    logic [63:0] key_hi = '0;
    logic [63:0] key_lo = '0;
    int   errors = 0;
    int   gap = 0;
    int   stall = 0;
    int   hold = 0;
    bit   hold_req = 0;
    bit   no_idle = 0;
    logic took = 1'b0;

    aes128_block_cipher u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic aes_pkg::byte_t gf_mul(aes_pkg::byte_t a, aes_pkg::byte_t b);
        aes_pkg::byte_t p;
        p = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic aes_pkg::byte_t rol8(aes_pkg::byte_t v, int n);
        return aes_pkg::byte_t'((v << n) | (v >> (8 - n)));
    endfunction

    function automatic void build_sbox();
        aes_pkg::byte_t inv, base;
        for (int x = 0; x < 256; x++) begin
            inv = 1;
            base = aes_pkg::byte_t'(x);
            for (int e = 254; e != 0; e >>= 1) begin
                if (e & 1) inv = gf_mul(inv, base);
                base = gf_mul(base, base);
            end
            sb[x] = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
            isb[sb[x]] = aes_pkg::byte_t'(x);
        end
    endfunction

    function automatic void expand_key();
        aes_pkg::byte_t rc;
        aes_pkg::word_t t;
        rc = 8'h01;
        sched[0] = key_hi[63:32];
        sched[1] = key_hi[31:0];
        sched[2] = key_lo[63:32];
        sched[3] = key_lo[31:0];
        for (int i = 4; i < 44; i++) begin
            t = sched[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sb[t[31:24]], sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]} ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end
            sched[i] = sched[i-4] ^ t;
        end
    endfunction

    function automatic blk_out_t aes_block(aes_pkg::mode_t mode, logic [63:0] hi,
                                           logic [63:0] lo);
        logic [127:0] b;
        aes_pkg::byte_t s[16], t[16], a[4], m[4];
        blk_out_t res;
        b = {hi, lo};
        for (int n = 0; n < 16; n++) s[n] = b[127-8*n -: 8];
        if (mode == aes_pkg::MODE_ENC) begin
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
            for (int n = 0; n < 16; n++) s[n] ^= sched[n/4][31-8*(n%4) -: 8];
            for (int rd = 1; rd <= 10; rd++) begin
                t = s;
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        s[4*c+r] = sb[t[4*((c+r)%4)+r]];
                if (rd != 10) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int j = 0; j < 4; j++) a[j] = s[4*c+j];
                        for (int r = 0; r < 4; r++)
                            s[4*c+r] = gf_mul(a[0], m[(4-r)&3]) ^ gf_mul(a[1], m[(5-r)&3]) ^
                                       gf_mul(a[2], m[(6-r)&3]) ^ gf_mul(a[3], m[(7-r)&3]);
                    end
                end
                for (int n = 0; n < 16; n++) s[n] ^= sched[4*rd+n/4][31-8*(n%4) -: 8];
            end
        end else begin
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
            for (int n = 0; n < 16; n++) s[n] ^= sched[40+n/4][31-8*(n%4) -: 8];
            for (int rd = 9; rd >= 0; rd--) begin
                t = s;
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        s[4*c+r] = isb[t[4*((c-r+4)%4)+r]];
                for (int n = 0; n < 16; n++) s[n] ^= sched[4*rd+n/4][31-8*(n%4) -: 8];
                if (rd != 0) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int j = 0; j < 4; j++) a[j] = s[4*c+j];
                        for (int r = 0; r < 4; r++)
                            s[4*c+r] = gf_mul(a[0], m[(4-r)&3]) ^ gf_mul(a[1], m[(5-r)&3]) ^
                                       gf_mul(a[2], m[(6-r)&3]) ^ gf_mul(a[3], m[(7-r)&3]);
                    end
                end
            end
        end
        for (int n = 0; n < 16; n++) b[127-8*n -: 8] = s[n];
        res.hi = b[127:64];
        res.lo = b[63:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle || r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch %s: expected %h got %h", what, want, got);
        errors++;
    endtask

    task automatic add_block(aes_pkg::mode_t mode, logic [63:0] hi, logic [63:0] lo);
        blk_item_t it;
        it.mode = mode;
        it.hi = hi;
        it.lo = lo;
        pend_q.push_back(it);
    endtask

    task automatic wait_idle();
        while (pend_q.size() != 0 || s_tvalid || cipher_q.size() != 0) @(negedge aclk);
        repeat (14) @(negedge aclk);
    endtask

    task automatic write_key(aes_pkg::reg_idx_t idx, logic [63:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == aes_pkg::REG_KEY_UPPER) key_hi = v;
        else key_lo = v;
        expand_key();
        // schedule sweep after a key write
        repeat (16) @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // both sides: the posedge records each transaction and its predicted result, and checks each result taken
    always @(posedge aclk) begin
        blk_out_t exp_out, got;
        if (aresetn && s_tvalid && s_tready) begin
            cipher_q.push_back(aes_block(s_tuser, s_tdata[63:0], s_tdata[127:64]));
            took <= 1'b1;
        end else begin
            took <= 1'b0;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.hi = m_tdata[63:0];
            got.lo = m_tdata[127:64];
            if (cipher_q.size() == 0) begin
                report("unexpected result", '0, got.hi);
            end else begin
                exp_out = cipher_q.pop_front();
                if (got.hi !== exp_out.hi) report("out_upper", exp_out.hi, got.hi);
                if (got.lo !== exp_out.lo) report("out_lower", exp_out.lo, got.lo);
            end
        end
    end

    always @(negedge aclk) begin
        blk_item_t it;
        if (aresetn && (!s_tvalid || took)) begin
            if (gap > 0) begin
                gap--;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() != 0) begin
                it = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {it.lo, it.hi};
                s_tuser <= it.mode;
                gap = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold > 0) begin
            hold--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 0;
            hold = 400;
            m_tready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall = pick_gap();
        end
    end

    initial begin
        #(8 * 400000);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [63:0] pt_hi, pt_lo;
        blk_out_t ct;
        build_sbox();
        expand_key();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all-zero key after reset
        add_block(aes_pkg::MODE_ENC, '0, '0);
        add_block(aes_pkg::MODE_DEC, '0, '0);
        add_block(aes_pkg::MODE_ENC, '1, '1);
        add_block(aes_pkg::MODE_DEC, '1, '1);
        add_block(aes_pkg::MODE_ENC, 64'h8000_0000_0000_0000, 64'h1);
        add_block(aes_pkg::MODE_DEC, 64'h1, 64'h8000_0000_0000_0000);
        wait_idle();

        // standard key and vector, both directions
        write_key(aes_pkg::REG_KEY_UPPER, 64'h0001_0203_0405_0607);
        write_key(aes_pkg::REG_KEY_LOWER, 64'h0809_0a0b_0c0d_0e0f);
        pt_hi = 64'h0011_2233_4455_6677;
        pt_lo = 64'h8899_aabb_ccdd_eeff;
        ct = aes_block(aes_pkg::MODE_ENC, pt_hi, pt_lo);
        add_block(aes_pkg::MODE_ENC, pt_hi, pt_lo);
        add_block(aes_pkg::MODE_DEC, ct.hi, ct.lo);
        add_block(aes_pkg::MODE_DEC, pt_hi, pt_lo);
        add_block(aes_pkg::MODE_ENC, '1, '0);
        wait_idle();

        // one half at a time, up to the all-ones key
        write_key(aes_pkg::REG_KEY_UPPER, '1);
        add_block(aes_pkg::MODE_ENC, '0, '1);
        add_block(aes_pkg::MODE_DEC, '1, '0);
        wait_idle();
        write_key(aes_pkg::REG_KEY_LOWER, '1);
        add_block(aes_pkg::MODE_ENC, '0, '0);
        add_block(aes_pkg::MODE_DEC, '0, '0);
        add_block(aes_pkg::MODE_ENC, '1, '1);
        add_block(aes_pkg::MODE_DEC, '1, '1);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 3))
                0: write_key(aes_pkg::REG_KEY_UPPER, rand64());
                1: write_key(aes_pkg::REG_KEY_LOWER, rand64());
                default: begin
                    write_key(aes_pkg::REG_KEY_UPPER, rand64());
                    write_key(aes_pkg::REG_KEY_LOWER, rand64());
                end
            endcase
            no_idle = (ph % 3 == 2);
            if (ph == 1) hold_req = 1;
            for (int i = 0; i < 300; i++) begin
                // some decrypts take back a ciphertext made earlier
                if ($urandom_range(0, 3) == 0) begin
                    pt_hi = rand64();
                    pt_lo = rand64();
                    ct = aes_block(aes_pkg::MODE_ENC, pt_hi, pt_lo);
                    add_block(aes_pkg::MODE_DEC, ct.hi, ct.lo);
                end else begin
                    add_block(aes_pkg::mode_t'($urandom_range(0, 1)), rand64(), rand64());
                end
            end
            wait_idle();
            no_idle = 0;
        end

        repeat (30) @(negedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: aes128_block_cipher.f
rtl/aes_pkg.sv
rtl/aes128_block_cipher.sv
rtl/aes_checker.sv
test/tb.sv
